>>> sv/bgc_pkg.sv
package bgc_pkg;

    // Sizes of the per-button state
    localparam int NUM_BUTTONS = 2;
    localparam int COUNT_LIMIT = 125;
    localparam int COUNT_W     = 8;
    localparam int THR_W       = 7;
    localparam logic [THR_W-1:0] THR_RESET = 7'd7;

    // Gesture codes as they leave on the result word
    typedef enum logic [1:0] {
        GEST_PRESS  = 2'd0,
        GEST_TAP    = 2'd1,
        GEST_DTAP   = 2'd2,
        GEST_TPRESS = 2'd3
    } gesture_t;

    // One scan sample held in the input stage
    typedef struct packed {
        logic button;
        logic pressed;
    } scan_t;

    // Classification of one scan sample
    typedef struct packed {
        logic     hit;
        logic     button;
        gesture_t gesture;
    } result_t;

endpackage

>>> sv/bgc_core.sv
module bgc_core (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        fire,
    input  bgc_pkg::scan_t              scan,
    input  logic [bgc_pkg::THR_W-1:0]   thr,
    output bgc_pkg::result_t            res
);
    import bgc_pkg::*;

    localparam logic signed [COUNT_W:0] LIM_POS = (COUNT_W+1)'(COUNT_LIMIT);
    localparam logic signed [COUNT_W:0] LIM_NEG = -LIM_POS;

    logic signed [COUNT_W-1:0] count_reg [NUM_BUTTONS];
    logic                      tap_reg   [NUM_BUTTONS];

    logic signed [COUNT_W:0]   cur;
    logic signed [COUNT_W:0]   thr_s;
    logic signed [COUNT_W:0]   step;
    logic signed [COUNT_W:0]   cnt_next;
    logic                      tap_cur;
    logic                      tap_next;
    logic                      in_range;

    assign cur      = (COUNT_W+1)'(count_reg[scan.button]);
    assign tap_cur  = tap_reg[scan.button];
    assign thr_s    = $signed({2'b00, thr});
    assign in_range = (int'(scan.button) < NUM_BUTTONS);

    // Classify the sample and work out the new count and tap flag
    always_comb begin
        step        = '0;
        cnt_next    = cur;
        tap_next    = tap_cur;
        res.hit     = 1'b0;
        res.button  = scan.button;
        res.gesture = GEST_PRESS;
        if (scan.pressed) begin
            step     = (cur < 0) ? (COUNT_W+1)'(1) : cur + (COUNT_W+1)'(1);
            cnt_next = (step > LIM_POS) ? LIM_POS : step;
        end else if (cur > 0) begin
            if (tap_cur) begin
                res.hit     = in_range;
                res.gesture = (cur < thr_s) ? GEST_DTAP : GEST_TPRESS;
                tap_next    = 1'b0;
                cnt_next    = '0;
            end else if (cur >= thr_s) begin
                res.hit     = in_range;
                res.gesture = GEST_PRESS;
                cnt_next    = '0;
            end else begin
                tap_next = 1'b1;
                cnt_next = -(COUNT_W+1)'(1);
            end
        end else begin
            step     = cur - (COUNT_W+1)'(1);
            cnt_next = (step < LIM_NEG) ? LIM_NEG : step;
            if (tap_cur && (cnt_next <= -thr_s)) begin
                res.hit     = in_range;
                res.gesture = GEST_TAP;
                tap_next    = 1'b0;
                cnt_next    = '0;
            end
        end
    end

    // Write back the state of the scanned button
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < NUM_BUTTONS; i++) begin
                count_reg[i] <= '0;
                tap_reg[i]   <= 1'b0;
            end
        end else if (fire && in_range) begin
            count_reg[scan.button] <= cnt_next[COUNT_W-1:0];
            tap_reg[scan.button]   <= tap_next;
        end
    end

    // The count of button 0 never leaves the saturation range
    a_count_range: assert property (@(posedge aclk) disable iff (!aresetn)
        ($signed(count_reg[0]) <= COUNT_LIMIT) && ($signed(count_reg[0]) >= -COUNT_LIMIT))
        else $error("scan count of button 0 out of range");

    // A gesture is only ever reported on an up scan
    a_hit_on_up: assert property (@(posedge aclk) disable iff (!aresetn)
        res.hit |-> !scan.pressed)
        else $error("gesture reported on a down scan");

    // Reporting a gesture always leaves the tap flag clear
    a_hit_clears_tap: assert property (@(posedge aclk) disable iff (!aresetn)
        (fire && res.hit) |=> !tap_reg[$past(scan.button)])
        else $error("tap flag still set after a gesture");

endmodule

>>> sv/button_gesture_classifier_unit.sv
// Button gesture classifier. Each input word is one scan sample of one button
// and the block answers with zero or one result word (press, single tap,
// double tap, tap then press). One word is taken every clock cycle while the
// result side is not stalled. An accepted sample is held in the input register
// while the per-button count and tap flag go through a single read-modify-write,
// and the result is then loaded into the result register. A result word held
// back by m_tready stalls the input side. press_threshold is written on the cfg
// channel, which is always ready; the user must write it only while no words are
// in flight, and the block itself does not enforce this.
module button_gesture_classifier_unit (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        cfg_valid,
    output logic                        cfg_ready,
    input  logic [bgc_pkg::THR_W-1:0]   cfg_data,
    input  logic                        s_tvalid,
    output logic                        s_tready,
    input  logic [7:0]                  s_tdata,   // [0] button_index, [1] pressed
    output logic                        m_tvalid,
    input  logic                        m_tready,
    output logic [7:0]                  m_tdata    // [0] event_button, [2:1] gesture
);
    import bgc_pkg::*;

    logic [THR_W-1:0] thr_reg;
    logic             in_valid_reg;
    scan_t            in_reg;
    logic             out_valid_reg;
    logic             out_button_reg;
    gesture_t         out_gesture_reg;
    logic             out_free;
    logic             fire;
    result_t          res;

    assign cfg_ready = 1'b1;
    assign out_free  = !out_valid_reg || m_tready;
    assign fire      = in_valid_reg && out_free;
    assign s_tready  = !in_valid_reg || out_free;
    assign m_tvalid  = out_valid_reg;
    assign m_tdata   = {5'b0, out_gesture_reg, out_button_reg};

    // Hold the threshold register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            thr_reg <= THR_RESET;
        end else if (cfg_valid && cfg_ready) begin
            thr_reg <= cfg_data;
        end
    end

    // Input stage: take a word whenever the stage is empty or draining
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_tready) begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tready && s_tvalid) begin
            in_reg.button  <= s_tdata[0];
            in_reg.pressed <= s_tdata[1];
        end
    end

    bgc_core u_core (
        .aclk    (aclk),
        .aresetn (aresetn),
        .fire    (fire),
        .scan    (in_reg),
        .thr     (thr_reg),
        .res     (res)
    );

    // Result stage: load on advance, drop once taken
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (out_free) begin
            out_valid_reg <= fire && res.hit;
        end
    end

    always_ff @(posedge aclk) begin
        if (fire && res.hit) begin
            out_button_reg  <= res.button;
            out_gesture_reg <= res.gesture;
        end
    end

    // A stalled sample stays in the input stage
    a_in_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (in_valid_reg && !out_free) |=> (in_valid_reg && $stable(in_reg)))
        else $error("input word lost while stalled");

    // A new result only follows an advancing sample that hit
    a_out_origin: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(out_valid_reg) |-> $past(fire && res.hit))
        else $error("result word without a source sample");

    // Input register is never overwritten while it cannot advance
    a_no_overrun: assert property (@(posedge aclk) disable iff (!aresetn)
        (in_valid_reg && !fire) |-> !s_tready)
        else $error("input accepted over a stalled word");

endmodule
